// ===== hdl/ctf_pkg.sv =====
// package: constants, types and helpers for the complementary tilt filter
`default_nettype none
package ctf_pkg;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int ACC_W   = 16;
    localparam int GYRO_W  = 24;
    localparam int ANG_W   = 25;
    localparam int EST_W   = 19;
    localparam int W_W     = 17;
    localparam int PER_W   = 32;
    localparam int CFG_W   = 32;
    localparam int CFG_AW  = 2;
    localparam int IN_W    = 3 * ACC_W + 2 * GYRO_W;
    localparam int IN_BYTES_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W   = 2 * ANG_W;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;
    localparam int QDEPTH  = 2;
    localparam logic signed [31:0] PI_Q16 = 32'sd205887;
    localparam logic signed [31:0] DEG_PER_RAD_Q24 = 32'sd961263669;
    localparam logic [W_W-1:0] ONE_Q16 = 17'd65536;

    typedef enum logic [CFG_AW-1:0] {
        REG_PITCH_W = 2'd0,
        REG_ROLL_W  = 2'd1,
        REG_PERIOD  = 2'd2,
        REG_DEGREES = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [ACC_W-1:0]  accel_x;
        logic signed [ACC_W-1:0]  accel_y;
        logic signed [ACC_W-1:0]  accel_z;
        logic signed [GYRO_W-1:0] gyro_x;
        logic signed [GYRO_W-1:0] gyro_y;
    } sample_t;

    typedef struct packed {
        logic         valid;
    } hs_t;

    function automatic logic signed [63:0] atan_q30(input int i);
        logic signed [63:0] t;
        case (i)
            0: t = 64'sd843314857;  1: t = 64'sd497837829;
            2: t = 64'sd263043837;  3: t = 64'sd133525159;
            4: t = 64'sd67021687;   5: t = 64'sd33543516;
            6: t = 64'sd16775851;   7: t = 64'sd8388437;
            8: t = 64'sd4194283;    9: t = 64'sd2097149;
            default: t = 64'sd1073741824 >>> i;
        endcase
        return t;
    endfunction
endpackage
`default_nettype wire

// ===== hdl/imu_complementary_tilt_filter_unit.sv =====
// an accepted request passes the root, cordic, round, multiply, blend, degree and output states before m_tvalid
// the back end works one sample at a time and takes the next only once it is back in idle
// a two-entry queue lets the next sample be taken while one is worked
// while a result waits the next sample is worked up to the degree stage
// reset: synchronous active low, clears both angles and loads register defaults
`default_nettype none
module imu_complementary_tilt_filter_unit
    import ctf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y
    input  wire logic [IN_BYTES_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // pitch_angle, roll_angle
    output logic [OUT_BYTES_W-1:0]      m_tdata,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_AW-1:0]      cfg_addr,
    input  wire logic [CFG_W-1:0]       cfg_wdata
);
    logic [W_W-1:0]   pw_reg, rw_reg;
    logic [PER_W-1:0] per_reg;
    logic             deg_reg;
    sample_t          in_s, q_s;
    hs_t              q_hs;
    logic             q_pop;
    logic [ANG_W-1:0] p_ang, r_ang;

    assign in_s.accel_x = s_tdata[15:0];
    assign in_s.accel_y = s_tdata[31:16];
    assign in_s.accel_z = s_tdata[47:32];
    assign in_s.gyro_x = s_tdata[71:48];
    assign in_s.gyro_y = s_tdata[95:72];
    assign m_tdata = {{(OUT_BYTES_W - OUT_W){1'b0}}, r_ang, p_ang};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pw_reg <= 17'd64225;
            rw_reg <= 17'd64225;
            per_reg <= 32'd42949673;
            deg_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                REG_PITCH_W: pw_reg <= cfg_wdata[W_W-1:0];
                REG_ROLL_W:  rw_reg <= cfg_wdata[W_W-1:0];
                REG_PERIOD:  per_reg <= cfg_wdata[PER_W-1:0];
                REG_DEGREES: deg_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    ctf_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_data(in_s), .q_hs_out(q_hs), .q_pop(q_pop), .q_data(q_s)
    );

    ctf_back #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_hs_in(q_hs), .q_pop(q_pop), .q_data(q_s),
        .pitch_w(pw_reg), .roll_w(rw_reg), .period(per_reg), .degrees(deg_reg),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_pitch(p_ang), .out_roll(r_ang)
    );
endmodule
`default_nettype wire

// ===== hdl/ctf_front.sv =====
// front end: sample intake queue
`default_nettype none
module ctf_front
    import ctf_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire sample_t in_data,
    output hs_t          q_hs_out,
    input  wire logic    q_pop,
    output sample_t      q_data
);
    sample_t          mem_reg [QDEPTH];
    logic             wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign q_hs_out.valid = (cnt_reg != 2'd0);
    assign q_data = mem_reg[rp_reg];

    always_comb begin
        wp_next = push ? ~wp_reg : wp_reg;
        rp_next = (q_pop && q_hs_out.valid) ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop && q_hs_out.valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[wp_reg] <= in_data;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/ctf_back.sv =====
// back end: root, cordic, blend and output stage
`default_nettype none
module ctf_back
    import ctf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire hs_t              q_hs_in,
    output logic                  q_pop,
    input  wire sample_t          q_data,
    input  wire logic [W_W-1:0]   pitch_w,
    input  wire logic [W_W-1:0]   roll_w,
    input  wire logic [PER_W-1:0] period,
    input  wire logic             degrees,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [ANG_W-1:0]      out_pitch,
    output logic [ANG_W-1:0]      out_roll
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001, S_SQRT = 8'b00000010, S_CORD = 8'b00000100,
        S_RND  = 8'b00001000, S_MUL  = 8'b00010000, S_BLND = 8'b00100000,
        S_DEG  = 8'b01000000, S_OUT  = 8'b10000000
    } st_t;

    localparam int ZW = FRAC_BITS + 4;
    localparam int UP = 16 - FRAC_BITS;

    st_t                st_reg, st_next;
    sample_t            smp_reg;
    logic [48:0]        n_reg [2];
    logic [48:0]        rt_reg [2];
    logic [48:0]        bit_reg;
    logic signed [40:0] x_reg [2];
    logic signed [40:0] y_reg [2];
    logic signed [ZW-1:0] z_reg [2];
    logic [4:0]         i_reg;
    logic signed [31:0] acc_reg [2];
    logic signed [EST_W-1:0] est_reg [2];
    logic signed [63:0] prod_reg;
    logic [1:0]         ph_reg;
    logic signed [31:0] emit_reg [2];
    logic               ovalid_reg;
    logic signed [63:0] zr [2];
    logic signed [63:0] r2 [2];
    logic signed [63:0] a_i;
    logic signed [63:0] r1, deg;
    logic signed [31:0] sat;
    logic signed [63:0] wv, s_v, dlt;
    logic               k;

    assign q_pop = (st_reg == S_IDLE) && q_hs_in.valid;
    assign out_valid = ovalid_reg;
    assign out_pitch = emit_reg[0][ANG_W-1:0];
    assign out_roll = emit_reg[1][ANG_W-1:0];

    always_comb begin
        a_i = (atan_q30(int'(i_reg)) + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        k = ph_reg[0];
        wv = {47'd0, (k ? roll_w : pitch_w) > ONE_Q16 ? ONE_Q16 : (k ? roll_w : pitch_w)};
        dlt = (prod_reg + (64'sd1 <<< 31)) >>> 32;
        s_v = 64'(est_reg[k]) + dlt;
        r1 = (wv * s_v + (64'sd65536 - wv) * 64'(acc_reg[k]) + 64'sd32768) >>> 16;
        sat = (r1 > 64'(PI_Q16)) ? PI_Q16 : ((r1 < -64'(PI_Q16)) ? -PI_Q16 : 32'(r1));
        deg = (64'(est_reg[k]) * 64'(DEG_PER_RAD_Q24) + (64'sd1 <<< 23)) >>> 24;
        for (int j = 0; j < 2; j++) begin
            r2[j] = 64'(z_reg[j]);
            if (UP >= 0) zr[j] = r2[j] <<< UP;
            else zr[j] = (r2[j] + (64'sd1 <<< (-UP - 1))) >>> (-UP);
        end
        st_next = st_reg;
        case (st_reg)
            S_IDLE: if (q_hs_in.valid) st_next = S_SQRT;
            S_SQRT: if (bit_reg == 49'd0) st_next = S_CORD;
            S_CORD: if (32'(i_reg) == CORDIC_STEPS - 1) st_next = S_RND;
            S_RND:  st_next = S_MUL;
            S_MUL:  st_next = S_BLND;
            S_BLND: st_next = ph_reg[0] ? S_DEG : S_MUL;
            S_DEG:  if (ph_reg[0] && !ovalid_reg) st_next = S_OUT;
            S_OUT:  st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            est_reg[0] <= '0;
            est_reg[1] <= '0;
            ovalid_reg <= 1'b0;
            ph_reg <= '0;
        end else begin
            st_reg <= st_next;
            if (st_reg == S_OUT) ovalid_reg <= 1'b1;
            else if (out_valid && out_ready) ovalid_reg <= 1'b0;
            case (st_reg)
                S_IDLE: begin
                    if (q_hs_in.valid) begin
                        smp_reg <= q_data;
                        n_reg[0] <= 49'(33'(q_data.accel_y) * 33'(q_data.accel_y)
                            + 33'(q_data.accel_z) * 33'(q_data.accel_z)) << 16;
                        n_reg[1] <= 49'(33'(q_data.accel_x) * 33'(q_data.accel_x)
                            + 33'(q_data.accel_z) * 33'(q_data.accel_z)) << 16;
                        rt_reg[0] <= '0;
                        rt_reg[1] <= '0;
                        bit_reg <= 49'd1 << 46;
                    end
                end
                S_SQRT: begin
                    if (bit_reg != 49'd0) begin
                        for (int j = 0; j < 2; j++) begin
                            if (n_reg[j] >= rt_reg[j] + bit_reg) begin
                                n_reg[j] <= n_reg[j] - (rt_reg[j] + bit_reg);
                                rt_reg[j] <= (rt_reg[j] >> 1) + bit_reg;
                            end else begin
                                rt_reg[j] <= rt_reg[j] >> 1;
                            end
                        end
                        bit_reg <= bit_reg >> 2;
                    end else begin
                        x_reg[0] <= 41'(rt_reg[0]);
                        x_reg[1] <= 41'(rt_reg[1]);
                        y_reg[0] <= -(41'(smp_reg.accel_x) <<< 8);
                        y_reg[1] <= 41'(smp_reg.accel_y) <<< 8;
                        z_reg[0] <= '0;
                        z_reg[1] <= '0;
                        i_reg <= '0;
                    end
                end
                S_CORD: begin
                    for (int j = 0; j < 2; j++) begin
                        if (y_reg[j] >= 0) begin
                            x_reg[j] <= x_reg[j] + (y_reg[j] >>> i_reg);
                            y_reg[j] <= y_reg[j] - (x_reg[j] >>> i_reg);
                            z_reg[j] <= z_reg[j] + ZW'(a_i);
                        end else begin
                            x_reg[j] <= x_reg[j] - (y_reg[j] >>> i_reg);
                            y_reg[j] <= y_reg[j] + (x_reg[j] >>> i_reg);
                            z_reg[j] <= z_reg[j] - ZW'(a_i);
                        end
                    end
                    i_reg <= i_reg + 5'd1;
                end
                S_RND: begin
                    acc_reg[0] <= (rt_reg[0] == 49'd0 && smp_reg.accel_x == 0)
                        ? 32'sd0 : 32'(zr[0]);
                    acc_reg[1] <= (rt_reg[1] == 49'd0 && smp_reg.accel_y == 0)
                        ? 32'sd0 : 32'(zr[1]);
                    ph_reg <= '0;
                end
                S_MUL: begin
                    prod_reg <= 64'(ph_reg[0] ? smp_reg.gyro_x : smp_reg.gyro_y)
                        * $signed({32'd0, period});
                end
                S_BLND: begin
                    est_reg[k] <= EST_W'(sat);
                    ph_reg <= ph_reg[0] ? 2'd0 : 2'd1;
                end
                S_DEG: begin
                    if (!ovalid_reg) begin
                        emit_reg[k] <= degrees ? 32'(deg) : 32'(est_reg[k]);
                        ph_reg <= ph_reg[0] ? 2'd0 : 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== tb/tb_imu_complementary_tilt_filter_unit.sv =====
// testbench: complementary tilt filter checked against a bit-exact predictor
`default_nettype none
module tb_imu_complementary_tilt_filter_unit;
    import ctf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 2000000;
    localparam int N_DIRECTED = 14;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_BYTES_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_BYTES_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    imu_complementary_tilt_filter_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    typedef struct packed {
        logic [ANG_W-1:0] roll;
        logic [ANG_W-1:0] pitch;
    } angles_t;

    typedef struct {
        logic [15:0] ax, ay, az;
        logic [23:0] gx, gy;
        logic        known;
        angles_t     want;
    } row_t;

    logic [16:0] w_pitch, w_roll;
    logic [31:0] period;
    logic        in_degrees;
    longint      est_pitch, est_roll;
    angles_t     angle_q[$];
    int          errors = 0;
    bit          quiet = 1'b0;
    longint      cycles = 0;
    int          out_idle = 0;
    row_t        rows[N_DIRECTED];

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_sh(longint v, int s);
        if (s == 0) return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint int_root(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint tilt_angle(longint num, longint den);
        longint x, y, z, dx, dy, a;
        x = den; y = num; z = 0;
        if (x == 0 && y == 0) return 0;
        for (int i = 0; i < 16; i++) begin
            a = round_sh(atan_q30(i), 14);
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0) begin
                x = x + dx; y = y - dy; z = z + a;
            end else begin
                x = x - dx; y = y + dy; z = z - a;
            end
        end
        return z;
    endfunction

    function automatic longint fuse(longint est, longint rate, logic [16:0] wr, longint acc);
        longint w, r;
        w = (wr > 17'd65536) ? 65536 : longint'(wr);
        r = round_sh(w * (est + round_sh(rate * longint'(period), 32))
                     + (65536 - w) * acc, 16);
        if (r > 205887) r = 205887;
        if (r < -205887) r = -205887;
        return r;
    endfunction

    function automatic logic [ANG_W-1:0] to_port(longint a);
        longint v;
        v = in_degrees ? round_sh(a * 961263669, 24) : a;
        return v[ANG_W-1:0];
    endfunction

    function automatic angles_t predict_angles(logic [15:0] ax, ay, az, logic [23:0] gx, gy);
        longint x, y, z;
        angles_t o;
        x = longint'($signed(ax)); y = longint'($signed(ay)); z = longint'($signed(az));
        est_pitch = fuse(est_pitch, longint'($signed(gy)), w_pitch,
            tilt_angle(-x * 256, int_root(longint'(y * y + z * z) << 16)));
        est_roll = fuse(est_roll, longint'($signed(gx)), w_roll,
            tilt_angle(y * 256, int_root(longint'(x * x + z * z) << 16)));
        o.pitch = to_port(est_pitch);
        o.roll = to_port(est_roll);
        return o;
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PITCH_W: w_pitch = v[16:0];
            REG_ROLL_W:  w_roll = v[16:0];
            REG_PERIOD:  period = v;
            REG_DEGREES: in_degrees = v[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (angle_q.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
    endtask

    task automatic send_sample(logic [15:0] ax, ay, az, logic [23:0] gx, gy,
                               logic known, angles_t want);
        angles_t p;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tdata <= {8'd0, gy, gx, az, ay, ax};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p = predict_angles(ax, ay, az, gx, gy);
        if (known && p !== want) begin
            $display("%0t table row disagrees: expected %h actual %h", $time, want, p);
            errors++;
        end
        angle_q.push_back(p);
    endtask

    task automatic random_sample();
        logic [15:0] ax, ay, az;
        logic [23:0] gx, gy;
        ax = $urandom; ay = $urandom; az = $urandom;
        gx = $urandom; gy = $urandom;
        case ($urandom_range(0, 3))
            0: begin
                ax = $signed(ax) >>> 8; ay = $signed(ay) >>> 8; az = $signed(az) >>> 8;
            end
            1: begin
                gx = $signed(gx) >>> 12; gy = $signed(gy) >>> 12;
            end
            default: ;
        endcase
        send_sample(ax, ay, az, gx, gy, 1'b0, '0);
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (angle_q.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %h",
                             $time, m_tdata[OUT_W-1:0]);
                    errors++;
                end else begin
                    if (m_tdata[ANG_W-1:0] !== angle_q[0].pitch) begin
                        $display("%0t pitch: expected %h actual %h", $time,
                                 angle_q[0].pitch, m_tdata[ANG_W-1:0]);
                        errors++;
                    end
                    if (m_tdata[OUT_W-1:ANG_W] !== angle_q[0].roll) begin
                        $display("%0t roll: expected %h actual %h", $time,
                                 angle_q[0].roll, m_tdata[OUT_W-1:ANG_W]);
                        errors++;
                    end
                    void'(angle_q.pop_front());
                end
            end
            if (quiet) begin
                out_idle = 0;
                m_tready <= 1'b1;
            end else if (out_idle > 1) begin
                out_idle = out_idle - 1;
                m_tready <= 1'b0;
            end else if (out_idle == 0 && $urandom_range(0, 7) == 0) begin
                out_idle = $urandom_range(1, 16);
                m_tready <= 1'b0;
            end else begin
                out_idle = 0;
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        // after reset both angles are zero; level sample with zero rates stays zero
        rows[0] = '{16'h0000, 16'h0000, 16'h0000, 24'h0, 24'h0, 1'b1, '0};
        rows[1] = '{16'h0000, 16'h0000, 16'h4000, 24'h0, 24'h0, 1'b1, '0};
        rows[2] = '{16'h7fff, 16'h0000, 16'h0000, 24'h0, 24'h0, 1'b0, '0};
        rows[3] = '{16'h8000, 16'h0000, 16'h0000, 24'h0, 24'h0, 1'b0, '0};
        rows[4] = '{16'h0000, 16'h7fff, 16'h0000, 24'h0, 24'h0, 1'b0, '0};
        rows[5] = '{16'h0000, 16'h8000, 16'h0000, 24'h0, 24'h0, 1'b0, '0};
        rows[6] = '{16'h0000, 16'h0000, 16'h8000, 24'h0, 24'h0, 1'b0, '0};
        rows[7] = '{16'h8000, 16'h8000, 16'h8000, 24'h7fffff, 24'h7fffff, 1'b0, '0};
        rows[8] = '{16'h7fff, 16'h7fff, 16'h7fff, 24'h800000, 24'h800000, 1'b0, '0};
        rows[9] = '{16'hffff, 16'h0001, 16'hffff, 24'hffffff, 24'h000001, 1'b0, '0};
        rows[10] = '{16'h0000, 16'h0000, 16'h0000, 24'h7fffff, 24'h7fffff, 1'b0, '0};
        rows[11] = '{16'h0000, 16'h0000, 16'h0000, 24'h7fffff, 24'h7fffff, 1'b0, '0};
        rows[12] = '{16'h1234, 16'hedcb, 16'h3000, 24'h800000, 24'h800000, 1'b0, '0};
        rows[13] = '{16'h0000, 16'h0000, 16'h0000, 24'h800000, 24'h800000, 1'b0, '0};
        w_pitch = 17'd64225; w_roll = 17'd64225;
        period = 32'd42949673; in_degrees = 1'b0;
        est_pitch = 0; est_roll = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_sample(rows[i].ax, rows[i].ay, rows[i].az, rows[i].gx, rows[i].gy,
                        rows[i].known, rows[i].want);
        drain();
        // weight above one, full period, degrees
        write_reg(REG_PITCH_W, 32'h1ffff);
        write_reg(REG_ROLL_W, 32'd0);
        write_reg(REG_PERIOD, 32'hffffffff);
        write_reg(REG_DEGREES, 32'd1);
        for (int i = 0; i < 6; i++)
            send_sample(rows[i + 7].ax, rows[i + 7].ay, rows[i + 7].az,
                        rows[i + 7].gx, rows[i + 7].gy, 1'b0, '0);
        drain();
        write_reg(REG_PERIOD, 32'd0);
        write_reg(REG_PITCH_W, 32'd65536);
        for (int i = 0; i < 4; i++) random_sample();
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            write_reg(REG_PITCH_W, $urandom_range(0, 8) == 0 ? $urandom : $urandom_range(0, 65536));
            write_reg(REG_ROLL_W, $urandom_range(0, 8) == 0 ? $urandom : $urandom_range(60000, 65536));
            write_reg(REG_PERIOD, ph == 0 ? 32'd4295 : $urandom);
            write_reg(REG_DEGREES, $urandom);
            if (ph == 8) quiet = 1'b1;
            for (int i = 0; i < 200; i++) random_sample();
            drain();
        end

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
